### hdl/rnss_pkg.sv
// ----------------------------------------------------------------------------
// rnss_pkg
// Shared types and constants of the node segment splitter.
// ----------------------------------------------------------------------------
package rnss_pkg;

    // Segment geometry
    localparam int NODES    = 16;
    localparam int RANK_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int STEP_W   = (RANK_W > 1) ? $clog2(RANK_W) : 1;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int BPN_W    = 41;
    localparam int NRANK_W  = 6;
    localparam int QID_W    = 8;
    localparam int END_W    = ADDR_W + 1;
    localparam int DIV_W    = (ADDR_W > BPN_W + RANK_W) ? ADDR_W : BPN_W + RANK_W;

    // Register reset value: 1 GiB per node
    localparam logic [BPN_W-1:0] BPN_RESET = BPN_W'(64'd1073741824);

    // Depth of the queue between front and back
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    // Result status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Transfer request
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] local_start;
        logic [ADDR_W-1:0] seg_base;
        logic [ADDR_W-1:0] global_start;
        logic [ADDR_W-1:0] byte_count;
        logic [QID_W-1:0]  queue_id;
    } req_t;

    // One piece of a split transfer
    typedef struct packed {
        logic               direction;
        logic [ADDR_W-1:0]  piece_local;
        logic [ADDR_W-1:0]  piece_remote;
        logic [BPN_W-1:0]   piece_length;
        logic [NRANK_W-1:0] node_rank;
        logic [QID_W-1:0]   queue_out;
        logic               status;
        logic               last_piece;
    } piece_t;

    // Classified job handed from front to back
    typedef struct packed {
        logic               mode;
        logic [ADDR_W-1:0]  local_start;
        logic [ADDR_W-1:0]  seg_base;
        logic [BPN_W-1:0]   node_off;
        logic [ADDR_W-1:0]  byte_count;
        logic [NRANK_W-1:0] rank;
        logic [QID_W-1:0]   queue_id;
        logic               err;
    } job_t;

endpackage

### hdl/rnss_req_if.sv
// ----------------------------------------------------------------------------
// rnss_req_if
// Valid/ready channel carrying transfer requests.
// ----------------------------------------------------------------------------
interface rnss_req_if import rnss_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rnss_piece_if.sv
// ----------------------------------------------------------------------------
// rnss_piece_if
// Valid/ready channel carrying split transfer pieces.
// ----------------------------------------------------------------------------
interface rnss_piece_if import rnss_pkg::*; ();
    logic   valid;
    logic   ready;
    piece_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/rnss_front.sv
// ----------------------------------------------------------------------------
// rnss_front
// Accepts requests, drops empty ones, checks the range and finds the start
// rank and offset within the node by shift-subtract division.
// ----------------------------------------------------------------------------
module rnss_front import rnss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [BPN_W-1:0] bpn,
    rnss_req_if.sink         req,
    output logic             push,
    output job_t             push_data,
    input  logic             full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]        state_reg,  state_next;
    logic [STEP_W-1:0] step_reg,   step_next;
    logic [DIV_W-1:0]  rem_reg,    rem_next;
    logic [RANK_W-1:0] quot_reg,   quot_next;
    logic              err_reg,    err_next;
    job_t              job_reg,    job_next;

    logic              accept;
    logic [END_W-1:0]  end_sum;
    logic [END_W-1:0]  span;
    logic [DIV_W-1:0]  dvs;
    logic              ge;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Range check: end of transfer against the whole striped segment
    assign end_sum = END_W'(req.data.global_start) + END_W'(req.data.byte_count);
    assign span    = END_W'(bpn) * END_W'(NODES);

    // One quotient bit per cycle
    assign dvs = DIV_W'(bpn) << step_reg;
    assign ge  = (rem_reg >= dvs);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        err_next   = err_reg;
        job_next   = job_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.data.byte_count != '0))
                begin
                    job_next.mode        = req.data.mode;
                    job_next.local_start = req.data.local_start;
                    job_next.seg_base    = req.data.seg_base;
                    job_next.byte_count  = req.data.byte_count;
                    job_next.queue_id    = req.data.queue_id;
                    rem_next             = DIV_W'(req.data.global_start);
                    quot_next            = '0;
                    step_next            = STEP_W'(RANK_W - 1);
                    err_next             = (end_sum > span);
                    state_next           = (end_sum > span) ? ST_PUSH : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dvs;
                end
                quot_next = RANK_W'({quot_reg, ge});
                if (step_reg == '0)
                begin
                    state_next = ST_PUSH;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_PUSH:
            begin
                if (!full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Job handed to the queue
    always_comb
    begin
        push_data          = job_reg;
        push_data.node_off = BPN_W'(rem_reg);
        push_data.rank     = NRANK_W'(quot_reg);
        push_data.err      = err_reg;
    end
    assign push = (state_reg == ST_PUSH) && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        err_reg  <= err_next;
        job_reg  <= job_next;
    end

    // Checks
    a_rank_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !push_data.err) |-> (push_data.rank < NRANK_W'(NODES)))
        else $error("start rank beyond last node");

    a_empty_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.data.byte_count == '0)) |=> (state_reg == ST_IDLE))
        else $error("empty request not dropped");

endmodule

### hdl/rnss_queue.sv
// ----------------------------------------------------------------------------
// rnss_queue
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module rnss_queue import rnss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_data,
    output logic full,
    input  logic pop,
    output job_t pop_data,
    output logic empty
);

    job_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg,  count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/rnss_back.sv
// ----------------------------------------------------------------------------
// rnss_back
// Walks one job node by node and emits one piece per cycle into the
// output register while it is empty or piece.ready takes its piece.
// ----------------------------------------------------------------------------
module rnss_back import rnss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [BPN_W-1:0] bpn,
    input  job_t             pop_data,
    input  logic             empty,
    output logic             pop,
    rnss_piece_if.source     piece
);

    logic               active_reg, active_next;
    logic               mode_reg,   mode_next;
    logic [ADDR_W-1:0]  local_reg,  local_next;
    logic [ADDR_W-1:0]  rbase_reg,  rbase_next;
    logic [BPN_W-1:0]   within_reg, within_next;
    logic [ADDR_W-1:0]  left_reg,   left_next;
    logic [NRANK_W-1:0] rank_reg,   rank_next;
    logic [QID_W-1:0]   queue_reg,  queue_next;
    logic               err_reg,    err_next;
    logic               out_valid_reg, out_valid_next;
    piece_t             out_data_reg,  out_data_next;

    logic [BPN_W-1:0]   room;
    logic               fits;
    logic               is_last;
    logic [BPN_W-1:0]   len;
    logic               emit;

    // Piece length: rest of the transfer or rest of the node
    assign room    = bpn - within_reg;
    assign fits    = (left_reg < ADDR_W'(room));
    assign is_last = err_reg || (left_reg <= ADDR_W'(room));
    assign len     = fits ? BPN_W'(left_reg) : room;

    assign emit = active_reg && (!out_valid_reg || piece.ready);
    assign pop  = !active_reg && !empty;

    assign piece.valid = out_valid_reg;
    assign piece.data  = out_data_reg;

    always_comb
    begin
        active_next    = active_reg;
        mode_next      = mode_reg;
        local_next     = local_reg;
        rbase_next     = rbase_reg;
        within_next    = within_reg;
        left_next      = left_reg;
        rank_next      = rank_reg;
        queue_next     = queue_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && piece.ready)
        begin
            out_valid_next = 1'b0;
        end

        // Load next job
        if (pop)
        begin
            active_next = 1'b1;
            mode_next   = pop_data.mode;
            local_next  = pop_data.local_start;
            rbase_next  = pop_data.seg_base;
            within_next = pop_data.node_off;
            left_next   = pop_data.byte_count;
            rank_next   = pop_data.rank;
            queue_next  = pop_data.queue_id;
            err_next    = pop_data.err;
        end

        // Emit one piece and advance the cursors
        if (emit)
        begin
            out_valid_next             = 1'b1;
            out_data_next.direction    = mode_reg;
            out_data_next.queue_out    = queue_reg;
            out_data_next.last_piece   = is_last;
            if (err_reg)
            begin
                out_data_next.piece_local  = '0;
                out_data_next.piece_remote = '0;
                out_data_next.piece_length = '0;
                out_data_next.node_rank    = '0;
                out_data_next.status       = STATUS_RANGE;
            end
            else
            begin
                out_data_next.piece_local  = local_reg;
                out_data_next.piece_remote = rbase_reg + ADDR_W'(within_reg);
                out_data_next.piece_length = len;
                out_data_next.node_rank    = rank_reg;
                out_data_next.status       = STATUS_OK;
            end
            local_next = local_reg + ADDR_W'(len);
            left_next  = left_reg - ADDR_W'(len);
            if (fits)
            begin
                within_next = within_reg + len;
            end
            else
            begin
                within_next = '0;
                rank_next   = rank_reg + 1'b1;
            end
            if (is_last)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        local_reg    <= local_next;
        rbase_reg    <= rbase_next;
        within_reg   <= within_next;
        left_reg     <= left_next;
        rank_reg     <= rank_next;
        queue_reg    <= queue_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    // Checks
    a_piece_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && !err_reg) |-> (len != '0))
        else $error("zero-length piece emitted");

    a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && is_last) |=> !active_reg)
        else $error("job still active after last piece");

endmodule

### hdl/rdma_node_segment_splitter_top.sv
// ----------------------------------------------------------------------------
// rdma_node_segment_splitter_top
// Splits remote-DMA transfer requests into pieces that stay within one node
// of an evenly striped segment.
//
//   channel   dir   handshake        payload
//   req       in    valid / ready    req_t   (one transfer request)
//   piece     out   valid / ready    piece_t (one piece or range error)
//   cfg       in    cfg_we           cfg_wdata = bytes_per_node
//
// After the accepting edge a request goes through shift-subtract division of
// the start offset, enters the queue and is loaded by the back, which then
// emits one piece per cycle while piece.ready is high. The front takes a new
// request once the previous one is queued. Requests with zero bytes leave no
// transaction; out-of-range requests skip the division and give one error
// piece. The output register lets the back stall on piece.ready while the
// front classifies the next request. Reset clears all control state and sets
// bytes_per_node to 1 GiB.
// ----------------------------------------------------------------------------
module rdma_node_segment_splitter_top import rnss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [BPN_W-1:0] cfg_wdata,
    rnss_req_if.sink         req,
    rnss_piece_if.source     piece
);

    logic [BPN_W-1:0] bpn_reg;
    logic [BPN_W-1:0] bpn_eff;
    logic             push;
    job_t             push_data;
    logic             full;
    logic             pop;
    job_t             pop_data;
    logic             empty;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpn_reg <= BPN_RESET;
        end
        else if (cfg_we)
        begin
            bpn_reg <= cfg_wdata;
        end
    end

    // Zero node size acts as one
    assign bpn_eff = (bpn_reg == '0) ? BPN_W'(1) : bpn_reg;

    rnss_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .bpn       (bpn_eff),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    rnss_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rnss_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .bpn      (bpn_eff),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .piece    (piece)
    );

endmodule
